[hdl/i2cmbe_pkg.sv]
// Package: command codes, classified command type and phase constants of the I2C byte engine.
`timescale 1ns / 1ps

package i2cmbe_pkg;

    // operation codes on the request channel
    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_RSTART = 3'd1;
    localparam logic [2:0] OP_STOP   = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // classified command kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // half-period phase counts
    localparam int PH_W        = 5;
    localparam int BUS_PHASES  = 3;
    localparam int BYTE_PHASES = 18;
    localparam int DATA_PHASES = 16;

    localparam int QUEUE_DEPTH_DEF = 2;

    // data: tx byte for write, rx byte for read
    // flag: acked for write, SDA level of the acknowledge bit for read
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       flag;
    } cmd_t;

endpackage

[hdl/i2cmbe_front.sv]
// Front stage: accept requests, classify them, drop unknown operations.
`timescale 1ns / 1ps

module i2cmbe_front
    import i2cmbe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_operation,
    input  logic [7:0] s_tx_byte,
    input  logic       s_send_ack,
    input  logic [8:0] s_sda_samples,
    output logic       q_valid,
    input  logic       q_ready,
    output cmd_t       q_cmd
);

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    logic known;

    always_comb begin
        known         = 1'b1;
        cmd_next.kind = KIND_START;
        cmd_next.data = 8'd0;
        cmd_next.flag = 1'b0;
        case (s_operation)
            OP_START, OP_RSTART: begin
                cmd_next.kind = KIND_START;
            end
            OP_STOP: begin
                cmd_next.kind = KIND_STOP;
            end
            OP_WRITE: begin
                cmd_next.kind = KIND_WRITE;
                cmd_next.data = s_tx_byte;
                cmd_next.flag = ~s_sda_samples[0];
            end
            OP_READ: begin
                cmd_next.kind = KIND_READ;
                cmd_next.data = s_sda_samples[8:1];
                cmd_next.flag = ~s_send_ack;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_cmd   = cmd_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid && known;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid && known) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

[hdl/i2cmbe_queue.sv]
// Short command queue between the front stage and the phase sequencer.
`timescale 1ns / 1ps

module i2cmbe_queue
    import i2cmbe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

endmodule

[hdl/i2cmbe_back.sv]
// Phase sequencer: expand one command into its half-period bus phases.
`timescale 1ns / 1ps

module i2cmbe_back
    import i2cmbe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  cmd_t       q_cmd,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_level,
    output logic       m_sda_level,
    output logic       m_last_phase,
    output logic [7:0] m_rx_byte,
    output logic       m_acked
);

    logic            busy_reg, busy_next;
    logic [PH_W-1:0] phase_reg, phase_next;
    cmd_t            cmd_reg;
    logic            out_valid_reg, out_valid_next;
    logic            scl_reg, sda_reg, last_reg, acked_reg;
    logic [7:0]      rx_reg;

    logic            issue, is_last, bus_cmd, pop;
    logic            scl_ph, sda_ph;
    logic [7:0]      rx_ph;
    logic            acked_ph;

    assign bus_cmd = (cmd_reg.kind == KIND_START) || (cmd_reg.kind == KIND_STOP);
    assign issue   = busy_reg && (!out_valid_reg || m_ready);
    assign is_last = bus_cmd ? (phase_reg == PH_W'(BUS_PHASES - 1))
                             : (phase_reg == PH_W'(BYTE_PHASES - 1));
    assign q_ready = !busy_reg || (issue && is_last);
    assign pop     = q_valid && q_ready;

    // line levels of the current phase
    always_comb begin
        scl_ph   = phase_reg[0];
        sda_ph   = 1'b1;
        rx_ph    = 8'd0;
        acked_ph = 1'b0;
        case (cmd_reg.kind)
            KIND_START: begin
                scl_ph = phase_reg != '0;
                sda_ph = phase_reg != PH_W'(2);
            end
            KIND_STOP: begin
                scl_ph = phase_reg != '0;
                sda_ph = phase_reg == PH_W'(2);
            end
            KIND_WRITE: begin
                if (phase_reg < PH_W'(DATA_PHASES)) begin
                    sda_ph = cmd_reg.data[3'd7 - phase_reg[3:1]];
                end
                if (is_last) begin
                    acked_ph = cmd_reg.flag;
                end
            end
            KIND_READ: begin
                if (phase_reg >= PH_W'(DATA_PHASES)) begin
                    sda_ph = cmd_reg.flag;
                end
                if (is_last) begin
                    rx_ph = cmd_reg.data;
                end
            end
            default: begin
                sda_ph = 1'b1;
            end
        endcase
    end

    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        if (pop) begin
            busy_next  = 1'b1;
            phase_next = '0;
        end else if (issue && is_last) begin
            busy_next = 1'b0;
        end else if (issue) begin
            phase_next = phase_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (issue) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= q_cmd;
        end
        if (issue) begin
            scl_reg   <= scl_ph;
            sda_reg   <= sda_ph;
            last_reg  <= is_last;
            rx_reg    <= rx_ph;
            acked_reg <= acked_ph;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_scl_level  = scl_reg;
    assign m_sda_level  = sda_reg;
    assign m_last_phase = last_reg;
    assign m_rx_byte    = rx_reg;
    assign m_acked      = acked_reg;

    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (phase_reg < PH_W'(BYTE_PHASES)))
        else $error("phase counter past byte length");

    a_bus_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && bus_cmd) |-> (phase_reg < PH_W'(BUS_PHASES)))
        else $error("phase counter past start/stop length");

    a_status_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !last_reg) |-> (rx_reg == 8'd0 && !acked_reg))
        else $error("status fields set before last phase");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && is_last && !q_valid) |=> !busy_reg)
        else $error("sequencer stays busy after last phase");

endmodule

[hdl/i2c_master_byte_engine.sv]
// Top level of the I2C master byte engine: front stage, command queue, phase sequencer.
//
//  channel   | direction | handshake         | payload
//  ----------+-----------+-------------------+---------------------------------------------
//  request   | in        | s_valid / s_ready | s_operation, s_tx_byte, s_send_ack,
//            |           |                   | s_sda_samples
//  phase     | out       | m_valid / m_ready | m_scl_level, m_sda_level, m_last_phase,
//            |           |                   | m_rx_byte, m_acked
//
// One phase result leaves per cycle while m_ready is high and commands are queued: start, repeated start and stop
// have 3 phases, write and read have 18, set by the phase counter in the sequencer.
// A request passes the front register, the queue and the sequencer's phase and output
// registers before its first phase appears. Unknown operation codes are accepted and dropped.
// Reset (aresetn low, synchronous) empties the front register, queue and sequencer.
// A stall on m_ready holds the sequencer; requests keep flowing into the front
// stage and queue until those fill.
`timescale 1ns / 1ps

module i2c_master_byte_engine
    import i2cmbe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_operation,
    input  logic [7:0] s_tx_byte,
    input  logic       s_send_ack,
    input  logic [8:0] s_sda_samples,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_level,
    output logic       m_sda_level,
    output logic       m_last_phase,
    output logic [7:0] m_rx_byte,
    output logic       m_acked
);

    // front stage -> queue
    logic f_valid, f_ready;
    cmd_t f_cmd;
    // queue -> sequencer
    logic b_valid, b_ready;
    cmd_t b_cmd;

    // classify the request, drop unknown codes
    i2cmbe_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_tx_byte     (s_tx_byte),
        .s_send_ack    (s_send_ack),
        .s_sda_samples (s_sda_samples),
        .q_valid       (f_valid),
        .q_ready       (f_ready),
        .q_cmd         (f_cmd)
    );

    // decouple the front from the sequencer
    i2cmbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_cmd   (b_cmd)
    );

    // expand each command into its bus phases
    i2cmbe_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (b_valid),
        .q_ready      (b_ready),
        .q_cmd        (b_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_scl_level  (m_scl_level),
        .m_sda_level  (m_sda_level),
        .m_last_phase (m_last_phase),
        .m_rx_byte    (m_rx_byte),
        .m_acked      (m_acked)
    );

endmodule
